// ===== rtl/pba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pba_pkg
// shared types and constants of the page bitmap allocator
// ----------------------------------------------------------------------------
package pba_pkg;

  localparam int unsigned MaxPages  = 65536;
  localparam int unsigned WordBits  = 64;
  localparam int unsigned WordCount = MaxPages / WordBits;
  localparam int unsigned AddrW     = $clog2(WordCount);
  localparam int unsigned BitW      = $clog2(WordBits);
  localparam int unsigned PageW     = $clog2(MaxPages) + 1;

  localparam logic [1:0] RegPagesInUse   = 2'd0;
  localparam logic [1:0] RegProtectFirst = 2'd1;
  localparam logic [1:0] RegProtectLimit = 2'd2;

  localparam logic FuncAlloc = 1'b0;
  localparam logic FuncFree  = 1'b1;

  typedef struct packed {
    logic        func;
    logic [15:0] first_page;
    logic [16:0] run_pages;
  } pba_req_t;

  typedef struct packed {
    logic        granted;
    logic [15:0] granted_page;
  } pba_rsp_t;

  typedef enum logic [3:0] {
    StIdle,
    StClear,
    StFreeRd,
    StFreeWr,
    StScanRd,
    StScanChk,
    StMarkRd,
    StMarkWr,
    StDone
  } pba_state_e;

endpackage

`default_nettype wire

// ===== rtl/page_bitmap_allocator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// page_bitmap_allocator_core
// bitmap first-fit page allocator over a 1024 x 64 used-bit memory
//
// requests come in on req_* (valid/stall), one response per request leaves
// on rsp_* (valid/stall). configuration is a plain write port (cfg_we_i,
// cfg_idx_i, cfg_data_i); the user must write it only while idle (unchecked).
// after reset a clearing pass writes all ones to every memory word, one word
// a cycle, during which no request is taken.
// one request is worked at a time, one page per cycle, and every word touched
// is read before its pages are worked. a free of zero pages or from at or
// above the total, or an allocate of zero or of more than the total, goes
// straight to the response without touching the memory. an allocate that
// scans and fails scans the whole page total.
// the response is held in an output register until taken; the next request
// is accepted in the cycle after the response is loaded. while a response is
// stalled, one more request can be finished and then waits for the register.
// ----------------------------------------------------------------------------
module page_bitmap_allocator_core
  import pba_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     req_valid_i,
  output logic          req_stall_o,
  input  wire pba_req_t req_i,
  output logic          rsp_valid_o,
  input  wire logic     rsp_stall_i,
  output pba_rsp_t      rsp_o,
  input  wire logic     cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [16:0] cfg_data_i
);

  logic [WordBits-1:0] mem [WordCount];
  logic [WordBits-1:0] rdata_q;

  pba_state_e state_q, state_d;
  logic [PageW-1:0] pages_q;
  logic [15:0]      pfirst_q;
  logic [PageW-1:0] plimit_q;
  logic [PageW-1:0] page_q, page_d;     // current page
  logic [PageW-1:0] end_q, end_d;       // end page (exclusive)
  logic [PageW-1:0] start_q, start_d;   // run start
  logic [PageW-1:0] len_q, len_d;       // run length
  logic [PageW-1:0] cnt_q, cnt_d;
  logic [WordBits-1:0] word_q, word_d;  // working copy of a word
  logic        fresh_q;
  pba_rsp_t    res_q, res_d;
  pba_rsp_t    rsp_q, rsp_d;
  logic        rsp_vld_q, rsp_vld_d;

  logic        mem_we, mem_re;
  logic [AddrW-1:0] mem_addr;
  logic [WordBits-1:0] mem_wdata;

  logic [PageW-1:0] total;
  logic [PageW-1:0] page_nx;
  logic [PageW-1:0] free_end;
  logic [PageW-1:0] run_first;
  logic [BitW-1:0]  bit_idx;
  logic             last_in_word;
  logic             prot;
  logic             page_free;
  logic             run_hit;
  logic             rsp_free;
  logic [WordBits-1:0] cur;

  assign total = (pages_q > PageW'(MaxPages)) ? PageW'(MaxPages) : pages_q;
  assign page_nx = page_q + PageW'(1);
  assign bit_idx = page_q[BitW-1:0];
  assign last_in_word = &bit_idx;
  assign prot = (page_q >= {1'b0, pfirst_q}) && (page_q < plimit_q);
  assign free_end = {1'b0, req_i.first_page} + req_i.run_pages;
  assign page_free = !rdata_q[bit_idx];
  assign run_hit = page_free && (len_q + PageW'(1) == cnt_q);
  assign run_first = (len_q == '0) ? page_q : start_q;
  assign rsp_free = !rsp_vld_q || !rsp_stall_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClear;
      pages_q   <= PageW'(MaxPages);
      pfirst_q  <= '0;
      plimit_q  <= '0;
      page_q    <= '0;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      page_q    <= page_d;
      rsp_vld_q <= rsp_vld_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegPagesInUse:   pages_q  <= cfg_data_i;
          RegProtectFirst: pfirst_q <= cfg_data_i[15:0];
          RegProtectLimit: plimit_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    end_q   <= end_d;
    start_q <= start_d;
    len_q   <= len_d;
    cnt_q   <= cnt_d;
    word_q  <= word_d;
    fresh_q <= mem_re;
    res_q   <= res_d;
    rsp_q   <= rsp_d;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (req_valid_i) begin
          if (req_i.func == FuncFree) begin
            if (req_i.run_pages == '0 || {1'b0, req_i.first_page} >= total) begin
              state_d = StDone;
            end else begin
              state_d = StFreeRd;
            end
          end else if (req_i.run_pages == '0 || req_i.run_pages > total) begin
            state_d = StDone;
          end else begin
            state_d = StScanRd;
          end
        end
      end
      StClear:   if (page_q[AddrW-1:0] == AddrW'(WordCount - 1)) state_d = StIdle;
      StFreeRd:  state_d = StFreeWr;
      StFreeWr: begin
        if (page_nx >= end_q) state_d = StDone;
        else if (last_in_word) state_d = StFreeRd;
      end
      StScanRd:  state_d = StScanChk;
      StScanChk: begin
        if (run_hit) state_d = StMarkRd;
        else if (page_nx >= total) state_d = StDone;
        else if (last_in_word) state_d = StScanRd;
      end
      StMarkRd:  state_d = StMarkWr;
      StMarkWr: begin
        if (page_nx >= end_q) state_d = StDone;
        else if (last_in_word) state_d = StMarkRd;
      end
      StDone:    if (rsp_free) state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  // datapath and outputs
  always_comb begin
    page_d    = page_q;
    end_d     = end_q;
    start_d   = start_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    word_d    = word_q;
    res_d     = res_q;
    rsp_d     = rsp_q;
    rsp_vld_d = rsp_vld_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = page_q[BitW +: AddrW];
    mem_wdata = word_q;
    cur       = fresh_q ? rdata_q : word_q;
    req_stall_o = (state_q != StIdle);

    if (rsp_vld_q && !rsp_stall_i) rsp_vld_d = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (req_valid_i) begin
          cnt_d   = req_i.run_pages;
          len_d   = '0;
          start_d = '0;
          res_d   = '0;
          if (req_i.func == FuncFree) begin
            page_d = {1'b0, req_i.first_page};
            end_d  = (free_end > total) ? total : free_end;
            res_d.granted = 1'b1;
          end else begin
            page_d = '0;
          end
        end
      end
      StClear: begin
        mem_we    = 1'b1;
        mem_addr  = page_q[AddrW-1:0];
        mem_wdata = '1;
        page_d    = (page_q[AddrW-1:0] == AddrW'(WordCount - 1)) ? '0 : page_nx;
      end
      StFreeRd, StScanRd, StMarkRd: begin
        mem_re = 1'b1;
      end
      StFreeWr: begin
        if (!prot) cur[bit_idx] = 1'b0;
        word_d = cur;
        if (last_in_word || page_nx >= end_q) begin
          mem_we    = 1'b1;
          mem_wdata = cur;
        end
        page_d = page_nx;
      end
      StScanChk: begin
        if (page_free) begin
          if (len_q == '0) start_d = page_q;
          len_d = len_q + PageW'(1);
        end else begin
          len_d = '0;
        end
        if (run_hit) begin
          page_d = run_first;
          end_d  = run_first + cnt_q;
          res_d.granted      = 1'b1;
          res_d.granted_page = run_first[15:0];
        end else begin
          page_d = page_nx;
        end
      end
      StMarkWr: begin
        cur[bit_idx] = 1'b1;
        word_d = cur;
        if (last_in_word || page_nx >= end_q) begin
          mem_we    = 1'b1;
          mem_wdata = cur;
        end
        page_d = page_nx;
      end
      StDone: begin
        if (rsp_free) begin
          rsp_d     = res_q;
          rsp_vld_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign rsp_valid_o = rsp_vld_q;
  assign rsp_o       = rsp_q;

endmodule

`default_nettype wire
